### design/cns_pkg.sv
// Shared types, constants and character-class helpers for the call name scanner.
// No dependencies; imported by call_name_scanner.
`timescale 1ns / 1ps

package cns_pkg;

    localparam int MAX_NAME_DEF    = 99;
    localparam int OFFSET_BITS_DEF = 20;
    localparam int KEEP_CHARS      = 6;
    localparam int BYTE_W          = 8;

    // Keyword spellings, first character in the lowest byte
    localparam logic [39:0] KW_WHILE  = 40'h65_6C_69_68_77;
    localparam logic [23:0] KW_FOR    = 24'h72_6F_66;
    localparam logic [47:0] KW_SIZEOF = 48'h66_6F_65_7A_69_73;
    localparam logic [15:0] KW_IF     = 16'h66_69;
    localparam logic [31:0] KW_ELSE   = 32'h65_73_6C_65;
    localparam logic [47:0] KW_SWITCH = 48'h68_63_74_69_77_73;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    typedef enum logic [1:0] {
        M_SEEK,
        M_NAME,
        M_SPACE,
        M_PAREN
    } t_match;

    typedef enum logic [1:0] {
        C_NONE,
        C_SLASH,
        C_BLOCK,
        C_LINE
    } t_comment;

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    function automatic logic is_name_first(input logic [7:0] ch);
        return is_alpha(ch) || (ch == CH_UNDER);
    endfunction

    function automatic logic is_name_char(input logic [7:0] ch);
        return is_alpha(ch) || (ch >= 8'h30 && ch <= 8'h39) || (ch == CH_UNDER);
    endfunction

    // len is the name length, valid only when it is below seven
    function automatic logic kw_match(input logic [47:0] lead, input logic [2:0] len);
        return ((len == 3'd5) && (lead[39:0] == KW_WHILE))
            || ((len == 3'd3) && (lead[23:0] == KW_FOR))
            || ((len == 3'd6) && (lead[47:0] == KW_SIZEOF))
            || ((len == 3'd2) && (lead[15:0] == KW_IF))
            || ((len == 3'd4) && (lead[31:0] == KW_ELSE))
            || ((len == 3'd6) && (lead[47:0] == KW_SWITCH));
    endfunction

endpackage

### design/call_name_scanner.sv
// Call name scanner: one byte per cycle when not stalled. A result is registered after the byte
// that causes it is accepted (input register, then result register) and leaves when taken.
// Throughput: one item per cycle unless stalled; the per-byte state update sits between the input
// register and the result register, so each stage holds at most one item.
// While a result waits, a new item enters only if the input register is empty; with both
// registers full the input stalls until the result is taken.
// i_rst_n (synchronous, active low) clears all scan state, the offset and header_mode.
// Depends on cns_pkg.
`timescale 1ns / 1ps

module call_name_scanner
    import cns_pkg::*;
#(
    parameter int MAX_NAME    = MAX_NAME_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LEN_BITS    = $clog2(MAX_NAME + 1),
    parameter int DATA_W      = ((OFFSET_BITS + LEN_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel: bit 0 is header_mode
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    // input item stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] text_byte
    input  logic                s_axis_tuser,   // [0] start_of_text
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,   // name_offset, then name_length, zero pad
    output logic                m_axis_tuser    // [0] name_too_long
);

    // nonspace count saturates one past MAX_NAME
    localparam int CNT_BITS = $clog2(MAX_NAME + 2);
    localparam int LEAD_W   = KEEP_CHARS * BYTE_W;

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_sot;

    // result register
    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_out_offset;
    logic [LEN_BITS-1:0]    r_out_len;
    logic                   r_out_long;

    // scan state
    logic                   r_header_mode;
    t_match                 r_match,     n_match;
    t_comment               r_comment,   n_comment;
    logic                   r_star,      n_star;
    logic [15:0]            r_depth,     n_depth;
    logic [OFFSET_BITS-1:0] r_offset,    n_offset;
    logic [OFFSET_BITS-1:0] r_tok_start, n_tok_start;
    logic [CNT_BITS-1:0]    r_nsc,       n_nsc;
    logic [LEAD_W-1:0]      r_lead,      n_lead;

    logic                   emit;
    logic [LEN_BITS-1:0]    emit_len;
    logic                   emit_long;
    logic                   advance;

    // Stage 2 may move when the result register is empty or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'({r_out_len, r_out_offset});
    assign m_axis_tuser  = r_out_long;

    // Per-byte state update: start-of-text clear, braces, comments, then the matcher
    always_comb begin
        logic [7:0]             ch;
        t_match                 ms;
        t_comment               cs;
        logic                   star;
        logic [15:0]            depth;
        logic [OFFSET_BITS-1:0] at;
        logic [OFFSET_BITS-1:0] tstart;
        logic [CNT_BITS-1:0]    nsc;
        logic [LEAD_W-1:0]      lead;
        logic                   skip;
        logic                   is_kw;
        logic                   over;

        ch     = r_in_byte;
        ms     = r_match;
        cs     = r_comment;
        star   = r_star;
        depth  = r_depth;
        at     = r_offset;
        tstart = r_tok_start;
        nsc    = r_nsc;
        lead   = r_lead;
        skip   = 1'b0;
        emit   = 1'b0;

        if (r_in_sot) begin
            ms     = M_SEEK;
            cs     = C_NONE;
            star   = 1'b0;
            depth  = '0;
            at     = '0;
            tstart = '0;
            nsc    = '0;
            lead   = '0;
        end

        n_offset = at + OFFSET_BITS'(1);

        // braces count everywhere, comments included
        if (ch == CH_LBRACE) begin
            depth = depth + 16'd1;
        end else if (ch == CH_RBRACE) begin
            depth = depth - 16'd1;
        end

        unique case (cs)
            C_NONE: begin
                if (ch == CH_SLASH) begin
                    cs = C_SLASH;
                end
            end
            C_SLASH: begin
                if (ch == CH_SLASH) begin
                    cs = C_LINE;
                    ms = M_SEEK;
                end else if (ch == CH_STAR) begin
                    cs   = C_BLOCK;
                    ms   = M_SEEK;
                    star = 1'b0;
                end else begin
                    cs = C_NONE;
                end
            end
            C_BLOCK: begin
                skip = 1'b1;
                // the closing slash is swallowed by the comment
                if (star && ch == CH_SLASH) begin
                    cs   = C_NONE;
                    star = 1'b0;
                end else begin
                    star = (ch == CH_STAR);
                end
            end
            C_LINE: begin
                skip = 1'b1;
                if (ch == CH_NEWLINE) begin
                    cs = C_NONE;
                end
            end
            default: begin
                cs = C_NONE;
            end
        endcase

        is_kw     = (nsc < CNT_BITS'(KEEP_CHARS + 1)) && kw_match(lead, nsc[2:0]);
        over      = (nsc > CNT_BITS'(MAX_NAME));
        emit_len  = over ? LEN_BITS'(MAX_NAME) : LEN_BITS'(nsc);
        emit_long = over;

        if (!skip) begin
            if (ms == M_PAREN) begin
                emit = (r_header_mode || depth != 16'd0) && !is_kw;
                ms   = M_SEEK;
            end

            case (ms)
                M_SEEK: begin
                    if (is_name_first(ch)) begin
                        ms     = M_NAME;
                        tstart = at;
                        nsc    = CNT_BITS'(1);
                        lead   = LEAD_W'(ch);
                    end
                end
                M_NAME: begin
                    if (ch == CH_SPACE) begin
                        ms = M_SPACE;
                    end else if (ch == CH_LPAREN) begin
                        ms = M_PAREN;
                    end else if (!is_name_char(ch)) begin
                        ms = M_SEEK;
                    end else begin
                        for (int k = 0; k < KEEP_CHARS; k++) begin
                            if (nsc == CNT_BITS'(k)) begin
                                lead[k*BYTE_W +: BYTE_W] = ch;
                            end
                        end
                        if (nsc <= CNT_BITS'(MAX_NAME)) begin
                            nsc = nsc + CNT_BITS'(1);
                        end
                    end
                end
                default: begin
                    // after spaces: '(' closes, anything but space starts a new name
                    if (ch == CH_LPAREN) begin
                        ms = M_PAREN;
                    end else if (ch != CH_SPACE) begin
                        ms     = M_NAME;
                        tstart = at;
                        nsc    = CNT_BITS'(1);
                        lead   = LEAD_W'(ch);
                    end
                end
            endcase
        end

        n_match     = ms;
        n_comment   = cs;
        n_star      = star;
        n_depth     = depth;
        n_tok_start = tstart;
        n_nsc       = nsc;
        n_lead      = lead;
    end

    // Control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_header_mode <= 1'b0;
            r_match       <= M_SEEK;
            r_comment     <= C_NONE;
            r_star        <= 1'b0;
            r_depth       <= '0;
            r_offset      <= '0;
            r_tok_start   <= '0;
            r_nsc         <= '0;
            r_lead        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_header_mode <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && emit;
            end
            // commit the byte's update as it leaves the input register
            if (advance && r_in_valid) begin
                r_match     <= n_match;
                r_comment   <= n_comment;
                r_star      <= n_star;
                r_depth     <= n_depth;
                r_offset    <= n_offset;
                r_tok_start <= n_tok_start;
                r_nsc       <= n_nsc;
                r_lead      <= n_lead;
            end
        end
    end

    // Payload registers: hold until the next item or result replaces them
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_sot  <= s_axis_tuser;
        end
        if (advance && r_in_valid && emit) begin
            r_out_offset <= r_tok_start;
            r_out_len    <= emit_len;
            r_out_long   <= emit_long;
        end
    end

    // A clipped name always reports the cap as its length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_long) |-> (r_out_len == LEN_BITS'(MAX_NAME)))
        else $error("clipped name with length other than cap");

    // The nonspace count never passes one beyond the cap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nsc <= CNT_BITS'(MAX_NAME + 1))
        else $error("nonspace count out of range");

    // An open paren is only recorded outside comments
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_match == M_PAREN) |-> (r_comment == C_NONE))
        else $error("paren match inside comment");

    // A new result comes only from an item that was in the input register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result without a source item");

endmodule

### test/call_name_scanner_test.sv
// Self-checking testbench for call_name_scanner: streams C-like text through the
// scanner and checks each reported call name against a predictor of its own.
// Depends on cns_pkg and call_name_scanner only.
`timescale 1ns / 1ps

module call_name_scanner_test;
    import cns_pkg::*;

    localparam int     LEN_W         = $clog2(MAX_NAME_DEF + 1);
    localparam int     RES_W         = ((OFFSET_BITS_DEF + LEN_W + 7) / 8) * 8;
    localparam int     SETTLE_CYCLES = 8;      // margin for the scanner's input and result registers to drain
    localparam int     HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam longint TIMEOUT_NS    = 40_000_000;

    // One reported call name, as the scanner should emit it
    typedef struct packed {
        logic [OFFSET_BITS_DEF-1:0] offset;
        logic [LEN_W-1:0]           length;
        logic                       clipped;
    } call_name_t;

    // One source byte waiting to be sent; restart marks start_of_text
    typedef struct packed {
        logic [7:0] ch;
        logic       restart;
    } text_item_t;

    // Scoreboard: mirrors the scan state byte by byte and holds the call
    // names that the scanner still owes us, oldest first.
    class call_name_book;
        string      words[6];
        call_name_t calls_due[$];
        int         errors;
        int         checked;
        bit         header;

        t_match                     mstate;
        t_comment                   cstate;
        bit                         star;
        logic [15:0]                depth;
        logic [OFFSET_BITS_DEF-1:0] next_ofs;
        logic [OFFSET_BITS_DEF-1:0] name_at;
        int                         name_len;    // saturates at MAX_NAME_DEF + 1
        logic [47:0]                head_bytes;  // first bytes of the name, first lowest

        function new();
            words   = '{"while", "for", "sizeof", "if", "else", "switch"};
            header  = 1'b0;
            errors  = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            mstate     = M_SEEK;
            cstate     = C_NONE;
            star       = 1'b0;
            depth      = '0;
            next_ofs   = '0;
            name_at    = '0;
            name_len   = 0;
            head_bytes = '0;
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit name_body(logic [7:0] c);
            return letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER;
        endfunction

        function void open_name(logic [OFFSET_BITS_DEF-1:0] at, logic [7:0] c);
            mstate          = M_NAME;
            name_at         = at;
            name_len        = 1;
            head_bytes      = '0;
            head_bytes[7:0] = c;
        endfunction

        function void extend_name(logic [7:0] c);
            if (name_len < KEEP_CHARS)
                head_bytes[8*name_len +: 8] = c;
            if (name_len <= MAX_NAME_DEF)
                name_len++;
        endfunction

        function bit is_keyword();
            bit same;
            for (int w = 0; w < 6; w++) begin
                same = (name_len == words[w].len());
                for (int i = 0; same && i < words[w].len(); i++)
                    if (head_bytes[8*i +: 8] != words[w][i])
                        same = 1'b0;
                if (same)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the scan state by one accepted byte
        function void note_byte(logic [7:0] ch, logic sot);
            logic [OFFSET_BITS_DEF-1:0] here;
            call_name_t                 hit;
            if (sot)
                restart();
            here     = next_ofs;
            next_ofs = next_ofs + 1'b1;

            // braces count everywhere, comments included
            if (ch == CH_LBRACE)
                depth = depth + 1'b1;
            else if (ch == CH_RBRACE)
                depth = depth - 1'b1;

            case (cstate)
                C_NONE: begin
                    if (ch == CH_SLASH)
                        cstate = C_SLASH;
                end
                C_SLASH: begin
                    if (ch == CH_SLASH) begin
                        cstate = C_LINE;
                        mstate = M_SEEK;
                    end else if (ch == CH_STAR) begin
                        cstate = C_BLOCK;
                        mstate = M_SEEK;
                        star   = 1'b0;
                    end else begin
                        cstate = C_NONE;
                    end
                end
                C_BLOCK: begin
                    if (star && ch == CH_SLASH) begin
                        cstate = C_NONE;
                        star   = 1'b0;
                    end else begin
                        star = (ch == CH_STAR);
                    end
                    return;
                end
                default: begin
                    if (ch == CH_NEWLINE)
                        cstate = C_NONE;
                    return;
                end
            endcase

            // the byte after '(' reports the name, then is matched afresh
            if (mstate == M_PAREN) begin
                if ((header || depth != 0) && !is_keyword()) begin
                    hit.offset  = name_at;
                    hit.clipped = (name_len > MAX_NAME_DEF);
                    hit.length  = hit.clipped ? LEN_W'(MAX_NAME_DEF) : LEN_W'(name_len);
                    calls_due.push_back(hit);
                end
                mstate = M_SEEK;
            end

            case (mstate)
                M_SEEK: begin
                    if (letter(ch) || ch == CH_UNDER)
                        open_name(here, ch);
                end
                M_NAME: begin
                    if (ch == CH_SPACE)
                        mstate = M_SPACE;
                    else if (ch == CH_LPAREN)
                        mstate = M_PAREN;
                    else if (!name_body(ch))
                        mstate = M_SEEK;
                    else
                        extend_name(ch);
                end
                default: begin
                    // after spaces any other byte opens a new name, even a non-name byte
                    if (ch == CH_LPAREN)
                        mstate = M_PAREN;
                    else if (ch != CH_SPACE)
                        open_name(here, ch);
                end
            endcase
        endfunction

        // Compare one delivered result with the oldest call name due
        function void check_result(logic [OFFSET_BITS_DEF-1:0] ofs, logic [LEN_W-1:0] len,
                                   logic clipped, bit pad_clean);
            call_name_t want;
            if (calls_due.size() == 0) begin
                $error("result with no call name due: name_offset %0d name_length %0d",
                       ofs, len);
                errors++;
                return;
            end
            want = calls_due.pop_front();
            checked++;
            if (ofs !== want.offset) begin
                $error("name_offset: expected %0d, got %0d", want.offset, ofs);
                errors++;
            end
            if (len !== want.length) begin
                $error("name_length: expected %0d, got %0d", want.length, len);
                errors++;
            end
            if (clipped !== want.clipped) begin
                $error("name_too_long: expected %0b, got %0b", want.clipped, clipped);
                errors++;
            end
            if (!pad_clean) begin
                $error("tdata pad bits: expected 0, got nonzero");
                errors++;
            end
        endfunction
    endclass

    // Ports
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_data    = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = 8'h20;  // [7:0] text_byte
    logic             s_axis_tuser  = 1'b0;   // [0] start_of_text
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [RES_W-1:0] m_axis_tdata;           // [19:0] name_offset, [26:20] name_length
    logic             m_axis_tuser;           // [0] name_too_long

    call_name_book sb;
    text_item_t    text_q[$];
    bit            restart_next = 1'b0;
    bit            tx_calm      = 1'b0;  // sender offers back to back
    bit            rx_calm      = 1'b0;  // receiver always ready
    bit            hold_request = 1'b0;  // receiver holds off for HOLD_CYCLES
    int            bytes_sent   = 0;
    int            cfg_writes   = 0;
    int            stall_left   = 0;

    call_name_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Watch both handshakes at the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[OFFSET_BITS_DEF-1:0],
                                m_axis_tdata[OFFSET_BITS_DEF +: LEN_W], m_axis_tuser,
                                (m_axis_tdata >> (OFFSET_BITS_DEF + LEN_W)) === '0);
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Text generation: fragments of C-like source go into text_q
    // ---------------------------------------------------------------
    function automatic void push_char(logic [7:0] c);
        text_q.push_back(text_item_t'{ch: c, restart: restart_next});
        restart_next = 1'b0;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic logic [7:0] rand_name_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    // Mostly short names, some keywords, a few past the length cap
    function automatic void push_name();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            push_text(sb.words[$urandom_range(0, 5)]);
            return;
        end
        len = (r < 13) ? $urandom_range(95, 110) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            push_char(rand_name_char(i == 0));
    endfunction

    function automatic void add_fragment();
        string junk;
        string punct;
        int    k;
        int    n;
        junk  = "*{}a(/ \n*";
        punct = ";,)=+ \n\t";
        k     = $urandom_range(0, 99);
        if (k < 40) begin
            // call: name, maybe spaces, open paren
            push_name();
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < n; i++)
                push_char(CH_SPACE);
            push_char(CH_LPAREN);
        end else if (k < 48) begin
            push_name();
            push_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (k < 58) begin
            push_char(CH_LBRACE);
        end else if (k < 64) begin
            push_char(CH_RBRACE);
        end else if (k < 68) begin
            // block comment, now and then left open
            push_text("/*");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
                push_char(junk[$urandom_range(0, junk.len() - 1)]);
            if ($urandom_range(0, 9) != 0)
                push_text("*/");
        end else if (k < 71) begin
            push_text("//");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                push_char(junk[$urandom_range(0, junk.len() - 2)]);
            push_char(CH_NEWLINE);
        end else if (k < 86) begin
            push_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (k < 95) begin
            push_char(8'($urandom_range(1, 255)));
        end else if (k < 96) begin
            restart_next = 1'b1;
        end else begin
            push_text(sb.words[$urandom_range(0, 5)]);
            push_char(CH_LPAREN);
        end
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Offer one byte and return at the edge that accepts it; tvalid stays
    // high so the caller must follow with another byte or wait_idle.
    task automatic send_item(input logic [7:0] c, input logic sot);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= sot;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic flush_text();
        text_item_t it;
        while (text_q.size() > 0) begin
            it = text_q.pop_front();
            send_item(it.ch, it.restart);
        end
    endtask

    task automatic run_text(input int n);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n) begin
            add_fragment();
            flush_text();
        end
    endtask

    // Drop tvalid, wait for every due call name, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.calls_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header_mode(input bit v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.header = v;
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_header_mode(1'b0);

        // Directed: negative depth, digits and underscore, spaces before '('
        restart_next = 1'b1;
        push_text("}f (_9()");
        // every keyword suppressed, a near miss reported
        restart_next = 1'b1;
        push_text("{while(for(sizeof(if(else(switch(fore(;");
        // braces inside comments, star run before close, slash passes matcher
        restart_next = 1'b1;
        push_text("{a/*{b(* **/c(//d(\ne(;");
        // non-name byte after spaces opens a name; byte extremes
        restart_next = 1'b1;
        push_text("{h  9(;");
        push_char(8'h01);
        push_char(8'hFF);
        push_text("k(");
        push_char(8'hFF);
        // depth zero without header_mode: silent
        restart_next = 1'b1;
        push_text("g(;");
        flush_text();

        // Header mode at depth zero, keyword still suppressed, length cap
        write_header_mode(1'b1);
        restart_next = 1'b1;
        push_text("g(;if(;");
        for (int i = 0; i < MAX_NAME_DEF; i++)
            push_char("x");
        push_text("(;");
        for (int i = 0; i <= MAX_NAME_DEF; i++)
            push_char("y");
        push_text("  (;");
        for (int i = 0; i < 120; i++)
            push_char("z");
        push_text("(;");
        flush_text();

        // Random text. Header on: hold the receiver off while bytes keep coming.
        hold_request = 1'b1;
        tx_calm      = 1'b1;
        run_text(160);
        tx_calm = 1'b0;
        run_text(220);

        // Header off: pause the sender mid-phase until everything is out
        write_header_mode(1'b0);
        run_text(190);
        wait_idle();
        run_text(180);

        // Header on: a stretch with no idling on either side
        write_header_mode(1'b1);
        rx_calm = 1'b1;
        tx_calm = 1'b1;
        run_text(120);
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        run_text(260);

        write_header_mode(1'b0);
        run_text(380);

        wait_idle();
        $display("Scanned %0d bytes of directed and random text over %0d header_mode writes;",
                 bytes_sent, cfg_writes);
        $display("%0d call names compared, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop if the scanner hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
